@@ design/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types, codes and defaults for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int PRIO_W    = 4;
	localparam int TAG_W     = 32;
	localparam int OCC_W     = 5;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	// per-cell control from the queue controller
	typedef struct packed {
		logic enq;  // insert this cycle (queue not full)
		logic deq;  // remove head this cycle (queue not empty)
		logic occ;  // cell holds a live entry
		logic tail; // cell is the first free slot
	} cell_ctl_t;

endpackage

@@ design/spq_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted row: compares, shifts back, shifts forward or loads.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic                              clk,
	input  spq_pkg::cell_ctl_t                ctl,
	input  logic [spq_pkg::PRIO_W-1:0]        new_prio,
	input  logic [spq_pkg::TAG_W-1:0]         new_tag,
	input  spq_pkg::entry_t                   prev_entry,
	input  logic                              prev_gb,
	input  spq_pkg::entry_t                   next_entry,
	output spq_pkg::entry_t                   entry,
	output logic                              gb
);

	spq_pkg::entry_t entry_q;

	// new entry is more urgent than this one: this one moves back
	assign gb    = ctl.occ && (new_prio < entry_q.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.enq) begin
			if (prev_gb) begin
				entry_q <= prev_entry;
			end else if (gb || ctl.tail) begin
				entry_q.prio <= new_prio;
				entry_q.tag  <= new_tag;
			end
		end else if (ctl.deq) begin
			entry_q <= next_entry;
		end
	end

endmodule

@@ design/sorted_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded priority queue held as a sorted row of shifting cells.
// ----------------------------------------------------------------------------
// Takes one request per clock while the result side keeps up; each result
// is registered and appears in the cycle after its request. The row of cells
// allows this: every cell compares the incoming priority with its own entry
// and shifts or loads in the same cycle, so no insert or removal slows down
// with DEPTH. A finished result sits in the output register; in_stall
// rises only while that register is full and out_stall is high. Enqueue puts
// the entry behind all entries of equal priority; dequeue returns the smallest
// priority number, oldest first. Enqueue on a full queue gives status FULL,
// dequeue on an empty queue gives status EMPTY, both leaving the queue as is.
// occupancy is the entry count after the request, kept to its low five bits.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  logic [spq_pkg::PRIO_W-1:0]     priority_req,
	input  logic [spq_pkg::TAG_W-1:0]      payload,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [spq_pkg::PRIO_W-1:0]     out_priority,
	output logic [spq_pkg::TAG_W-1:0]      out_payload,
	output logic [spq_pkg::OCC_W-1:0]      occupancy
);

	localparam int CntW = $clog2(DEPTH + 1);

	logic [CntW-1:0]  count_q;
	logic             out_valid_q;
	spq_pkg::status_t status_q;
	logic [spq_pkg::PRIO_W-1:0] prio_q;
	logic [spq_pkg::TAG_W-1:0]  tag_q;

	spq_pkg::entry_t  cell_q [DEPTH];
	logic [DEPTH-1:0] gb;

	logic in_acc;
	logic is_enq;
	logic full;
	logic empty;
	logic do_enq;
	logic do_deq;
	logic [CntW-1:0] count_nxt;
	logic [31:0]     count_ext;

	// hold requests only while a result waits and downstream stalls
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign is_enq   = (operation == spq_pkg::OP_ENQ);
	assign full     = (count_q == CntW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_enq   = in_acc && is_enq && !full;
	assign do_deq   = in_acc && !is_enq && !empty;

	always_comb begin
		count_nxt = count_q;
		if (do_enq) begin
			count_nxt = count_q + CntW'(1);
		end else if (do_deq) begin
			count_nxt = count_q - CntW'(1);
		end
	end

	assign count_ext = 32'(count_nxt);

	// row of cells, head at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_pkg::cell_ctl_t ctl;
		spq_pkg::entry_t    prev_e;
		spq_pkg::entry_t    next_e;
		logic               prev_g;

		assign ctl.enq  = do_enq;
		assign ctl.deq  = do_deq;
		assign ctl.occ  = (count_q > CntW'(i));
		assign ctl.tail = (count_q == CntW'(i));

		if (i == 0) begin : g_head
			assign prev_e = '0;
			assign prev_g = 1'b0;
		end else begin : g_mid
			assign prev_e = cell_q[i-1];
			assign prev_g = gb[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_e = '0;
		end else begin : g_body
			assign next_e = cell_q[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_prio   (priority_req),
			.new_tag    (payload),
			.prev_entry (prev_e),
			.prev_gb    (prev_g),
			.next_entry (next_e),
			.entry      (cell_q[i]),
			.gb         (gb[i])
		);
	end

	// count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= spq_pkg::ST_DONE;
			occupancy   <= '0;
		end else begin
			count_q <= count_nxt;
			if (in_acc) begin
				out_valid_q <= 1'b1;
				occupancy   <= count_ext[spq_pkg::OCC_W-1:0];
				if (is_enq) begin
					status_q <= full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
				end else begin
					status_q <= empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_DONE;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// dequeued entry, zero for everything else
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (do_deq) begin
				prio_q <= cell_q[0].prio;
				tag_q  <= cell_q[0].tag;
			end else begin
				prio_q <= '0;
				tag_q  <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_priority = prio_q;
	assign out_payload  = tag_q;

	// count stays within the row
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("entry count beyond DEPTH");

	// rejected enqueue reports full on the next result
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_enq && full |=> out_valid && status == spq_pkg::ST_FULL)
		else $error("full enqueue not reported");

	// successful dequeue drops the count by one
	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_deq |=> count_q == $past(count_q) - CntW'(1))
		else $error("dequeue count mismatch");

	// head is never less urgent than its neighbor
	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CntW'(2) |-> cell_q[0].prio <= cell_q[1].prio)
		else $error("head out of order");

endmodule
